// File: rtl/core/fwnms_pkg.sv
package fwnms_pkg;

  localparam int KeptDepthDef = 64;

  localparam int CoordW = 12;
  localparam int LabelW = 4;
  localparam int LimitW = 8;
  localparam int SpanW  = 4;
  localparam int AreaW  = 2 * SpanW;

  localparam logic [CoordW-1:0] RowSpan    = CoordW'(15);
  localparam logic [CoordW-1:0] ColSpan    = CoordW'(11);
  localparam logic [LimitW-1:0] LimitReset = LimitW'(55);

  localparam logic KindClear  = 1'b0;
  localparam logic KindDetect = 1'b1;

  typedef struct packed {
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] col;
  } coord_t;

endpackage

// File: rtl/core/fixed_window_nms.sv
// Greedy suppression of fixed 15x11 detection windows.
// Command channel: an item is taken at a clock edge with start_i high and
// busy_o low. kind_i low clears the kept list and returns no result; kind_i
// high offers a detection (row_i, col_i, label_i), which must come in order
// of descending score.
// A detection is compared with each kept detection, one entry per cycle,
// through a single overlap/compare unit fed by the kept-list memory read
// port. Scan stops at the first overlap above the limit.
// Result: a detection gives its result (res_strobe_o high for one cycle)
// from registers loaded when its scan ends; the entries compared are at
// most the kept count. busy_o is high during the scan; the next item can
// be taken in the cycle the result shows. A clear does not make the block
// busy.
// Config: overlap_limit is written through cfg_valid_i/cfg_ready_o/cfg_data_i
// while the block is idle.
// Reset: kept list empty, limit 55, no result pending. The receiver cannot
// stall: each result is valid for exactly its strobe cycle.
module fixed_window_nms import fwnms_pkg::*; #(
  parameter int KEPT_DEPTH = KeptDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              kind_i,
  input  logic [CoordW-1:0] row_i,
  input  logic [CoordW-1:0] col_i,
  input  logic [LabelW-1:0] label_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [LimitW-1:0] cfg_data_i,
  output logic              res_strobe_o,
  output logic              kept_o,
  output logic [CoordW-1:0] out_row_o,
  output logic [CoordW-1:0] out_col_o,
  output logic [LabelW-1:0] out_label_o,
  output logic              overflow_o
);

  localparam int IdxW = (KEPT_DEPTH > 1) ? $clog2(KEPT_DEPTH) : 1;
  localparam int CntW = $clog2(KEPT_DEPTH + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(KEPT_DEPTH);

  localparam logic StIdle = 1'b0;
  localparam logic StScan = 1'b1;

  logic              state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   issue_q, issue_d;
  logic              pend_q, pend_d;
  logic [LimitW-1:0] limit_q;
  coord_t            cand_q;
  logic [LabelW-1:0] label_q;

  logic              strobe_q, strobe_d;
  logic              kept_q;
  logic              ovf_q;
  coord_t            res_pos_q;
  logic [LabelW-1:0] res_label_q;

  logic   accept;
  logic   hit;
  logic   done;
  logic   keep;
  logic   full;
  logic   rd_en;
  logic   wr_en;
  coord_t rdata;

  assign accept = start_i && (state_q == StIdle);
  assign busy_o = (state_q != StIdle);
  assign cfg_ready_o = (state_q == StIdle);

  fwnms_ovl u_ovl (
    .cand_i  (cand_q),
    .kept_i  (rdata),
    .limit_i (limit_q),
    .hit_o   (hit)
  );

  fwnms_store #(
    .Depth (KEPT_DEPTH),
    .IdxW  (IdxW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (count_q[IdxW-1:0]),
    .wdata_i (cand_q),
    .re_i    (rd_en),
    .raddr_i (issue_q[IdxW-1:0]),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    issue_d  = issue_q;
    pend_d   = 1'b0;
    strobe_d = 1'b0;
    rd_en    = 1'b0;
    wr_en    = 1'b0;
    done     = 1'b0;
    keep     = 1'b0;
    full     = 1'b0;
    case (state_q)
      StIdle: begin
        if (accept) begin
          issue_d = '0;
          if (kind_i == KindClear) begin
            count_d = '0;
          end else begin
            state_d = StScan;
          end
        end
      end
      StScan: begin
        done = (pend_q && hit) || (issue_q == count_q);
        if (done) begin
          keep     = !(pend_q && hit);
          full     = keep && (count_q == CntFull);
          wr_en    = keep && !full;
          strobe_d = 1'b1;
          state_d  = StIdle;
          if (wr_en) begin
            count_d = count_q + CntW'(1);
          end
        end else begin
          rd_en   = 1'b1;
          pend_d  = 1'b1;
          issue_d = issue_q + CntW'(1);
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      count_q  <= '0;
      issue_q  <= '0;
      pend_q   <= 1'b0;
      strobe_q <= 1'b0;
      limit_q  <= LimitReset;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      issue_q  <= issue_d;
      pend_q   <= pend_d;
      strobe_q <= strobe_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cand_q.row <= row_i;
      cand_q.col <= col_i;
      label_q    <= label_i;
    end
    if (done) begin
      kept_q      <= keep;
      ovf_q       <= full;
      res_pos_q   <= cand_q;
      res_label_q <= label_q;
    end
  end

  assign res_strobe_o = strobe_q;
  assign kept_o       = kept_q;
  assign overflow_o   = ovf_q;
  assign out_row_o    = res_pos_q.row;
  assign out_col_o    = res_pos_q.col;
  assign out_label_o  = res_label_q;

endmodule

// File: rtl/core/fwnms_store.sv
module fwnms_store import fwnms_pkg::*; #(
  parameter int Depth = KeptDepthDef,
  parameter int IdxW  = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  coord_t          wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output coord_t          rdata_o
);

  coord_t mem_q [Depth];
  coord_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/core/fwnms_ovl.sv
module fwnms_ovl import fwnms_pkg::*; (
  input  coord_t            cand_i,
  input  coord_t            kept_i,
  input  logic [LimitW-1:0] limit_i,
  output logic              hit_o
);

  logic [CoordW-1:0] dr;
  logic [CoordW-1:0] dc;
  logic [SpanW-1:0]  ra;
  logic [SpanW-1:0]  ca;
  logic [AreaW-1:0]  area;
  logic              near;

  always_comb begin
    dr = (cand_i.row > kept_i.row) ? (cand_i.row - kept_i.row) : (kept_i.row - cand_i.row);
    dc = (cand_i.col > kept_i.col) ? (cand_i.col - kept_i.col) : (kept_i.col - cand_i.col);
    near = (dr < RowSpan) && (dc < ColSpan);
    ra = SpanW'(RowSpan - dr);
    ca = SpanW'(ColSpan - dc);
    area = {{(AreaW-SpanW){1'b0}}, ra} * {{(AreaW-SpanW){1'b0}}, ca};
    hit_o = near && (area > limit_i);
  end

endmodule

// File: rtl/core/fwnms_chk.sv
module fwnms_chk import fwnms_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic kind_i,
  input logic res_strobe_o,
  input logic kept_o,
  input logic overflow_o
);

  logic take;
  assign take = start_i && !busy_o;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |=> !res_strobe_o)
    else $error("result strobe held for more than one cycle");

  a_strobe_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o |-> !busy_o)
    else $error("result shown while busy");

  a_detect_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && kind_i == KindDetect) |=> (busy_o && !res_strobe_o))
    else $error("detection transaction did not start a scan");

  a_clear_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && kind_i == KindClear) |=> (!busy_o && !res_strobe_o))
    else $error("clear transaction left the block busy");

  a_ovf_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && overflow_o) |-> kept_o)
    else $error("overflow on a suppressed detection");

endmodule

bind fixed_window_nms fwnms_chk u_fwnms_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .start_i      (start_i),
  .busy_o       (busy_o),
  .kind_i       (kind_i),
  .res_strobe_o (res_strobe_o),
  .kept_o       (kept_o),
  .overflow_o   (overflow_o)
);
